// ===== rtl/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the sorted allocation tracker.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 32;
  localparam int unsigned TagW  = 16;
  localparam int unsigned LineW = 20;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic do_insert; // shift-up and write at lower bound
    logic do_remove; // shift-down from match
    logic dump_clr;  // reset dump pointer
    logic dump_adv;  // advance dump pointer
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic dump_last;
  } stat_t;

endpackage

// ===== rtl/sat_datapath.sv =====
// ----------------------------------------------------------------------------
// sat_datapath
// Chain of sorted cells: parallel compare, parallel shift for insert/remove.
// ----------------------------------------------------------------------------
module sat_datapath #(
  parameter int unsigned TableDepth = sat_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sat_pkg::ctrl_t            ctrl_i,
  output sat_pkg::stat_t            stat_o,
  input  logic [1:0]                cmd_i,
  input  logic [sat_pkg::AddrW-1:0] address_i,
  input  logic [sat_pkg::SizeW-1:0] req_size_i,
  input  logic [sat_pkg::TagW-1:0]  site_tag_i,
  input  logic [sat_pkg::LineW-1:0] site_line_i,
  output logic [1:0]                cmd_o,
  output logic [sat_pkg::AddrW-1:0] rd_address_o,
  output logic [sat_pkg::SizeW-1:0] rd_size_o,
  output logic [sat_pkg::TagW-1:0]  rd_tag_o,
  output logic [sat_pkg::LineW-1:0] rd_line_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned IdxW = $clog2(TableDepth);

  logic [sat_pkg::AddrW-1:0] addr_q [TableDepth];
  logic [sat_pkg::SizeW-1:0] size_q [TableDepth];
  logic [sat_pkg::TagW-1:0]  tag_q  [TableDepth];
  logic [sat_pkg::LineW-1:0] line_q [TableDepth];

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  logic [1:0]                in_cmd_q;
  logic [sat_pkg::AddrW-1:0] in_addr_q;
  logic [sat_pkg::SizeW-1:0] in_size_q;
  logic [sat_pkg::TagW-1:0]  in_tag_q;
  logic [sat_pkg::LineW-1:0] in_line_q;

  logic [TableDepth-1:0] live, lt, eq, match;
  logic [TableDepth-1:0] fnd;

  // lt is monotone (sorted table): cell i is below key; match = first equal.
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      live[i] = CntW'(i) < count_q;
      lt[i]   = live[i] && (addr_q[i] < in_addr_q);
      eq[i]   = live[i] && (addr_q[i] == in_addr_q);
    end
    for (int i = 0; i < TableDepth; i++) begin
      if (i == 0) begin
        match[i] = eq[i];
      end else begin
        match[i] = eq[i] && lt[i-1];
      end
      fnd[i] = (i == 0) ? match[i] : (match[i] | fnd[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      in_addr_q <= address_i;
      in_size_q <= req_size_i;
      in_tag_q  <= site_tag_i;
      in_line_q <= site_line_i;
    end
    for (int i = 0; i < TableDepth; i++) begin
      if (ctrl_i.do_insert && live[i] && !lt[i]) begin
        if (i + 1 < TableDepth) begin
          addr_q[(i+1) % TableDepth] <= addr_q[i];
          size_q[(i+1) % TableDepth] <= size_q[i];
          tag_q[(i+1) % TableDepth]  <= tag_q[i];
          line_q[(i+1) % TableDepth] <= line_q[i];
        end
      end
      if (ctrl_i.do_insert && !lt[i] && (i == 0 || lt[(i+TableDepth-1) % TableDepth])) begin
        addr_q[i] <= in_addr_q;
        size_q[i] <= in_size_q;
        tag_q[i]  <= in_tag_q;
        line_q[i] <= in_line_q;
      end
      if (ctrl_i.do_remove && fnd[i] && i + 1 < TableDepth) begin
        addr_q[i] <= addr_q[(i+1) % TableDepth];
        size_q[i] <= size_q[(i+1) % TableDepth];
        tag_q[i]  <= tag_q[(i+1) % TableDepth];
        line_q[i] <= line_q[(i+1) % TableDepth];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.do_remove) begin
      count_d = count_q - CntW'(1);
    end
    ptr_d = ptr_q;
    if (ctrl_i.dump_clr) begin
      ptr_d = '0;
    end else if (ctrl_i.dump_adv) begin
      ptr_d = ptr_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      in_cmd_q <= sat_pkg::CMD_NONE;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (ctrl_i.load) begin
        in_cmd_q <= cmd_i;
      end
    end
  end

  assign stat_o.full      = count_q == CntW'(TableDepth);
  assign stat_o.empty     = count_q == '0;
  assign stat_o.found     = |match;
  assign stat_o.dump_last = (CntW'(ptr_q) + CntW'(1)) == count_q;

  assign cmd_o        = in_cmd_q;
  assign rd_address_o = addr_q[ptr_q];
  assign rd_size_o    = size_q[ptr_q];
  assign rd_tag_o     = tag_q[ptr_q];
  assign rd_line_o    = line_q[ptr_q];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("count overflow");
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.do_insert |=> count_q == $past(count_q) + CntW'(1)) else $error("insert count");
  a_rem_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.do_remove |-> stat_o.found) else $error("remove without match");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.do_insert && ctrl_i.do_remove)) else $error("insert and remove");

endmodule

// ===== rtl/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl
// Controller: sequences one transaction and drives the output register.
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  output logic                      valid_o,
  input  logic                      stall_i,
  output sat_pkg::ctrl_t            ctrl_o,
  input  sat_pkg::stat_t            stat_i,
  input  logic [1:0]                cmd_i,
  input  logic [sat_pkg::AddrW-1:0] rd_address_i,
  input  logic [sat_pkg::SizeW-1:0] rd_size_i,
  input  logic [sat_pkg::TagW-1:0]  rd_tag_i,
  input  logic [sat_pkg::LineW-1:0] rd_line_i,
  output logic [2:0]                status_o,
  output logic [sat_pkg::AddrW-1:0] out_address_o,
  output logic [sat_pkg::SizeW-1:0] out_size_o,
  output logic [sat_pkg::TagW-1:0]  out_site_tag_o,
  output logic [sat_pkg::LineW-1:0] out_line_o,
  output logic                      last_o
);

  sat_pkg::state_e state_q, state_d;
  logic ov_q, ov_d;
  logic out_free, emit;
  logic [2:0] st_d;
  logic       ent_d, last_d;

  assign out_free = !ov_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sat_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    emit    = 1'b0;
    st_d    = sat_pkg::ST_INSERTED;
    ent_d   = 1'b0;
    last_d  = 1'b1;
    stall_o = state_q != sat_pkg::S_IDLE;
    case (state_q)
      sat_pkg::S_IDLE: begin
        if (valid_i) begin
          ctrl_o.load     = 1'b1;
          ctrl_o.dump_clr = 1'b1;
          state_d         = sat_pkg::S_EXEC;
        end
      end
      sat_pkg::S_EXEC: begin
        case (cmd_i)
          sat_pkg::CMD_INSERT: begin
            if (out_free) begin
              emit = 1'b1;
              st_d = stat_i.full ? sat_pkg::ST_FULL : sat_pkg::ST_INSERTED;
              ctrl_o.do_insert = !stat_i.full;
              state_d = sat_pkg::S_IDLE;
            end
          end
          sat_pkg::CMD_REMOVE: begin
            if (out_free) begin
              emit = 1'b1;
              st_d = stat_i.found ? sat_pkg::ST_REMOVED : sat_pkg::ST_NOTFOUND;
              ctrl_o.do_remove = stat_i.found;
              state_d = sat_pkg::S_IDLE;
            end
          end
          sat_pkg::CMD_DUMP: begin
            if (stat_i.empty) begin
              if (out_free) begin
                emit = 1'b1;
                st_d = sat_pkg::ST_EMPTY;
                state_d = sat_pkg::S_IDLE;
              end
            end else begin
              state_d = sat_pkg::S_DUMP;
            end
          end
          default: state_d = sat_pkg::S_IDLE;
        endcase
      end
      sat_pkg::S_DUMP: begin
        if (out_free) begin
          emit   = 1'b1;
          st_d   = sat_pkg::ST_ENTRY;
          ent_d  = 1'b1;
          last_d = stat_i.dump_last;
          ctrl_o.dump_adv = 1'b1;
          if (stat_i.dump_last) begin
            state_d = sat_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sat_pkg::S_IDLE;
    endcase
    ov_d = emit ? 1'b1 : (ov_q && stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o       <= st_d;
      last_o         <= last_d;
      out_address_o  <= ent_d ? rd_address_i : '0;
      out_size_o     <= ent_d ? rd_size_i : '0;
      out_site_tag_o <= ent_d ? rd_tag_i : '0;
      out_line_o     <= ent_d ? rd_line_i : '0;
    end
  end

  assign valid_o = ov_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("overwrite of pending result");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sat_pkg::S_IDLE) |-> stall_o) else $error("accept while busy");
  a_dump_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sat_pkg::S_DUMP) |-> !stat_i.empty) else $error("dump of empty table");

endmodule

// ===== rtl/sorted_allocation_tracker.sv =====
// ----------------------------------------------------------------------------
// sorted_allocation_tracker
// Address-sorted allocation table with insert, remove and dump transactions.
// ----------------------------------------------------------------------------
// Insert/remove: input registered on accept, result registered in S_EXEC, then S_IDLE.
// Dump of N entries: S_EXEC, then S_DUMP emits N results, one per cycle unless stalled.
// Throughput is set by the controller: one transaction in flight at a time.
// Reset clears the live count and control state; table contents stay as-is.
module sorted_allocation_tracker #(
  parameter int unsigned TableDepth = sat_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [sat_pkg::AddrW-1:0] address_i,
  input  logic [sat_pkg::SizeW-1:0] req_size_i,
  input  logic [sat_pkg::TagW-1:0]  site_tag_i,
  input  logic [sat_pkg::LineW-1:0] site_line_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [2:0]                status_o,
  output logic [sat_pkg::AddrW-1:0] out_address_o,
  output logic [sat_pkg::SizeW-1:0] out_size_o,
  output logic [sat_pkg::TagW-1:0]  out_site_tag_o,
  output logic [sat_pkg::LineW-1:0] out_line_o,
  output logic                      last_o
);

  sat_pkg::ctrl_t ctrl;
  sat_pkg::stat_t stat;
  logic [1:0]                cmd_q;
  logic [sat_pkg::AddrW-1:0] rd_address;
  logic [sat_pkg::SizeW-1:0] rd_size;
  logic [sat_pkg::TagW-1:0]  rd_tag;
  logic [sat_pkg::LineW-1:0] rd_line;

  sat_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .address_i, .req_size_i, .site_tag_i, .site_line_i,
    .cmd_o(cmd_q), .rd_address_o(rd_address), .rd_size_o(rd_size),
    .rd_tag_o(rd_tag), .rd_line_o(rd_line)
  );

  sat_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .stall_o, .valid_o, .stall_i,
    .ctrl_o(ctrl), .stat_i(stat), .cmd_i(cmd_q),
    .rd_address_i(rd_address), .rd_size_i(rd_size),
    .rd_tag_i(rd_tag), .rd_line_i(rd_line),
    .status_o, .out_address_o, .out_size_o, .out_site_tag_o, .out_line_o, .last_o
  );

endmodule
